FILE: rtl/core/epef_pkg.sv
`default_nettype none

package epef_pkg;

	// Track store geometry.
	localparam int TRACK_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TRACK_DEPTH);
	localparam int CNT_W       = $clog2(TRACK_DEPTH + 1);
	localparam int MAXT_W      = 9;
	localparam int CMP_W       = (CNT_W > MAXT_W) ? CNT_W : MAXT_W;
	localparam int SECTORS     = 6;

	// Field widths.
	localparam int TRIG_W   = 8;
	localparam int SECT_W   = 3;
	localparam int LPHI_W   = 13;
	localparam int THETA_W  = 11;
	localparam int PHI_W    = 15;
	localparam int TAN_W    = 18;
	localparam int PROD_W   = 2 * TAN_W;
	localparam int PCFG_W   = 13;
	localparam int TCFG_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CIDX_W   = 3;
	localparam int VERD_W   = 3;
	localparam int COUNT_W  = 9;
	localparam int FRAC_W   = 12;

	localparam int TRIG_BIT = 5;

	localparam logic [LPHI_W-1:0]  LPHI_MAX    = LPHI_W'(5759);
	localparam logic [THETA_W-1:0] THETA_MAX   = THETA_W'(1439);
	localparam int                 TAN_ENTRIES = 1440;
	localparam logic [TAN_W-1:0]   TAN_MAX     = TAN_W'(262143);

	// Reset values of the configuration registers.
	localparam logic [PCFG_W-1:0] PHI_MEAN_RST  = PCFG_W'(2880);
	localparam logic [PCFG_W-1:0] PHI_WIDTH_RST = PCFG_W'(320);
	localparam logic [TCFG_W-1:0] TAN_MEAN_RST  = TCFG_W'(2662);
	localparam logic [TCFG_W-1:0] TAN_WIDTH_RST = TCFG_W'(614);
	localparam logic [MAXT_W-1:0] MAX_TRK_RST   = MAXT_W'(201);

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef enum logic [CIDX_W-1:0] {
		REG_PHI_MEAN  = 3'd0,
		REG_PHI_WIDTH = 3'd1,
		REG_TAN_MEAN  = 3'd2,
		REG_TAN_WIDTH = 3'd3,
		REG_MAX_TRK   = 3'd4
	} cfg_reg_t;

	typedef enum logic [VERD_W-1:0] {
		VERDICT_ACCEPT     = 3'd0,
		VERDICT_NO_TRIGGER = 3'd1,
		VERDICT_OVERFLOW   = 3'd2,
		VERDICT_FEW_TRACKS = 3'd3,
		VERDICT_NO_PAIR    = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_STORE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic load_item;
		logic rom_rd;
		logic set_ovf;
		logic scan_start;
		logic scan_issue;
		logic store;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic qual;
		logic eoe;
		logic ovf;
		logic at_limit;
		logic scan_done;
		logic busy;
		logic out_full;
	} status_t;

	typedef struct packed {
		logic signed [PHI_W-1:0] phi;
		logic [TAN_W-1:0]        tan;
	} track_entry_t;

	typedef logic [TAN_W-1:0] tan_rom_t [TAN_ENTRIES];

	// Azimuth offset of each sector in 1/16 degree; unknown sectors get none.
	function automatic logic signed [PHI_W-1:0] sector_offset(logic [SECT_W-1:0] sector);
		logic signed [PHI_W-1:0] off;
		case (sector)
			3'd1:    off = PHI_W'(960);
			3'd2:    off = PHI_W'(1920);
			3'd3:    off = PHI_W'(2880);
			3'd4:    off = PHI_W'(3840);
			3'd5:    off = -PHI_W'(960);
			default: off = '0;
		endcase
		return off;
	endfunction

	// Shift-and-subtract unsigned division used while the tan table is built.
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// tan(theta) in Q6.12 from truncated Taylor series in Q30.
	// Evaluated only while the ROM contents are elaborated.
	function automatic logic [TAN_W-1:0] tan_calc(int unsigned theta);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] q;
		longint      s;
		longint      c;
		x  = udiv64(64'(theta) * PI_Q30 + 64'd1440, 64'd2880);
		x2 = (x * x) >> 30;
		t  = x;
		s  = longint'(x);
		for (int k = 1; k <= 12; k++) begin
			t = udiv64((t * x2) >> 30, 64'(2 * k) * 64'(2 * k + 1));
			if ((k % 2) == 1) s = s - longint'(t);
			else s = s + longint'(t);
		end
		t = ONE_Q30;
		c = longint'(ONE_Q30);
		for (int k = 1; k <= 12; k++) begin
			t = udiv64((t * x2) >> 30, 64'(2 * k - 1) * 64'(2 * k));
			if ((k % 2) == 1) c = c - longint'(t);
			else c = c + longint'(t);
		end
		if (c <= 0) return TAN_MAX;
		if (s < 0) s = 0;
		q = udiv64((64'(s) << 12) + (64'(c) >> 1), 64'(c));
		return (q > 64'(TAN_MAX)) ? TAN_MAX : TAN_W'(q);
	endfunction

	function automatic tan_rom_t tan_rom_build();
		tan_rom_t r;
		for (int i = 0; i < TAN_ENTRIES; i++) begin
			r[i] = tan_calc(32'(i));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/epef_tan_rom.sv
`default_nettype none

module epef_tan_rom (
	input  wire logic                            clk,
	input  wire logic                            rd_en,
	input  wire logic [epef_pkg::THETA_W-1:0]    theta,
	output logic      [epef_pkg::TAN_W-1:0]      tan_q
);

	localparam epef_pkg::tan_rom_t TAN_ROM = epef_pkg::tan_rom_build();

	// Angles at or beyond ninety degrees read as the saturated value.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (theta > epef_pkg::THETA_MAX) tan_q <= epef_pkg::TAN_MAX;
			else tan_q <= TAN_ROM[theta];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/epef_ctrl.sv
`default_nettype none

module epef_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire epef_pkg::status_t status,
	output epef_pkg::cmd_t         cmd
);

	epef_pkg::state_t state_q;
	epef_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epef_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			epef_pkg::ST_IDLE: begin
				if (in_valid) state_d = epef_pkg::ST_DECIDE;
			end
			epef_pkg::ST_DECIDE: begin
				if (status.qual && !status.ovf && !status.at_limit) begin
					state_d = epef_pkg::ST_SCAN;
				end else if (status.eoe) begin
					state_d = epef_pkg::ST_RESULT;
				end else begin
					state_d = epef_pkg::ST_IDLE;
				end
			end
			epef_pkg::ST_SCAN: begin
				if (status.scan_done) state_d = epef_pkg::ST_DRAIN;
			end
			epef_pkg::ST_DRAIN: begin
				if (!status.busy) state_d = epef_pkg::ST_STORE;
			end
			epef_pkg::ST_STORE: begin
				state_d = status.eoe ? epef_pkg::ST_RESULT : epef_pkg::ST_IDLE;
			end
			epef_pkg::ST_RESULT: begin
				if (!status.out_full) state_d = epef_pkg::ST_IDLE;
			end
			default: state_d = epef_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			epef_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			epef_pkg::ST_DECIDE: begin
				cmd.rom_rd     = 1'b1;
				cmd.set_ovf    = status.qual && !status.ovf && status.at_limit;
				cmd.scan_start = status.qual && !status.ovf && !status.at_limit;
			end
			epef_pkg::ST_SCAN: begin
				cmd.scan_issue = !status.scan_done;
			end
			epef_pkg::ST_DRAIN: begin
			end
			epef_pkg::ST_STORE: begin
				cmd.store = 1'b1;
			end
			epef_pkg::ST_RESULT: begin
				cmd.emit = !status.out_full;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/epef_dp.sv
`default_nettype none

module epef_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire epef_pkg::cmd_t                   cmd,
	output epef_pkg::status_t                     status,
	input  wire logic                             cfg_we,
	input  wire logic [epef_pkg::CIDX_W-1:0]      cfg_index,
	input  wire logic [epef_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic [epef_pkg::TRIG_W-1:0]      trigger_bits,
	input  wire logic [epef_pkg::SECT_W-1:0]      track_sector,
	input  wire logic [epef_pkg::LPHI_W-1:0]      local_phi,
	input  wire logic [epef_pkg::THETA_W-1:0]     polar_theta,
	input  wire logic                             track_qualifies,
	input  wire logic                             end_of_event,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [epef_pkg::VERD_W-1:0]           verdict,
	output logic [epef_pkg::COUNT_W-1:0]          track_count
);

	localparam int PW = epef_pkg::PHI_W;
	localparam int XW = epef_pkg::PROD_W;

	// Configuration registers.
	logic [epef_pkg::PCFG_W-1:0] phi_mean_q;
	logic [epef_pkg::PCFG_W-1:0] phi_width_q;
	logic [epef_pkg::TCFG_W-1:0] tan_mean_q;
	logic [epef_pkg::TCFG_W-1:0] tan_width_q;
	logic [epef_pkg::MAXT_W-1:0] max_trk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phi_mean_q  <= epef_pkg::PHI_MEAN_RST;
			phi_width_q <= epef_pkg::PHI_WIDTH_RST;
			tan_mean_q  <= epef_pkg::TAN_MEAN_RST;
			tan_width_q <= epef_pkg::TAN_WIDTH_RST;
			max_trk_q   <= epef_pkg::MAX_TRK_RST;
		end else if (cfg_we) begin
			unique case (epef_pkg::cfg_reg_t'(cfg_index))
				epef_pkg::REG_PHI_MEAN:  phi_mean_q  <= cfg_data[epef_pkg::PCFG_W-1:0];
				epef_pkg::REG_PHI_WIDTH: phi_width_q <= cfg_data[epef_pkg::PCFG_W-1:0];
				epef_pkg::REG_TAN_MEAN:  tan_mean_q  <= cfg_data[epef_pkg::TCFG_W-1:0];
				epef_pkg::REG_TAN_WIDTH: tan_width_q <= cfg_data[epef_pkg::TCFG_W-1:0];
				epef_pkg::REG_MAX_TRK:   max_trk_q   <= cfg_data[epef_pkg::MAXT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Item registers; the absolute azimuth is formed on the way in.
	logic [epef_pkg::LPHI_W-1:0]  lphi_clamp;
	logic [epef_pkg::TRIG_W-1:0]  trig_q;
	logic                         qual_q;
	logic                         eoe_q;
	logic [epef_pkg::THETA_W-1:0] theta_q;
	logic signed [PW-1:0]         phi_q;
	logic [epef_pkg::TAN_W-1:0]   tan_q;

	assign lphi_clamp = (local_phi > epef_pkg::LPHI_MAX) ? epef_pkg::LPHI_MAX : local_phi;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			trig_q  <= trigger_bits;
			qual_q  <= track_qualifies;
			eoe_q   <= end_of_event;
			theta_q <= polar_theta;
			phi_q   <= $signed(PW'(lphi_clamp)) + epef_pkg::sector_offset(track_sector);
		end
	end

	epef_tan_rom u_tan_rom (
		.clk   (clk),
		.rd_en (cmd.rom_rd),
		.theta (theta_q),
		.tan_q (tan_q)
	);

	// Event state.
	logic [epef_pkg::CNT_W-1:0] count_q;
	logic [epef_pkg::CNT_W-1:0] idx_q;
	logic                       ovf_q;
	logic                       pair_q;
	logic [epef_pkg::CMP_W-1:0] limit;

	assign limit = (epef_pkg::CMP_W'(max_trk_q) < epef_pkg::CMP_W'(epef_pkg::TRACK_DEPTH)) ?
		epef_pkg::CMP_W'(max_trk_q) : epef_pkg::CMP_W'(epef_pkg::TRACK_DEPTH);

	// Track store.
	epef_pkg::track_entry_t mem [epef_pkg::TRACK_DEPTH];
	epef_pkg::track_entry_t rd_s1;
	logic                   vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[count_q[epef_pkg::ADDR_W-1:0]] <= '{phi: phi_q, tan: tan_q};
		end
		if (cmd.scan_issue) begin
			rd_s1 <= mem[idx_q[epef_pkg::ADDR_W-1:0]];
		end
	end

	// Stage 1: azimuth window test and tan product.
	logic signed [PW:0]   dphi;
	logic [PW-1:0]        dphi_abs;
	logic signed [PW:0]   dev;
	logic [PW-1:0]        dev_abs;
	logic                 phi_ok;
	logic [XW-1:0]        prod_s2;
	logic                 phi_ok_s2;
	logic                 vld_s2;

	assign dphi     = $signed({rd_s1.phi[PW-1], rd_s1.phi}) - $signed({phi_q[PW-1], phi_q});
	assign dphi_abs = dphi[PW] ? PW'(-dphi) : PW'(dphi);
	assign dev      = $signed({1'b0, dphi_abs}) - $signed((PW + 1)'(phi_mean_q));
	assign dev_abs  = dev[PW] ? PW'(-dev) : PW'(dev);
	assign phi_ok   = dev_abs < PW'(phi_width_q);

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2   <= XW'(tan_q) * XW'(rd_s1.tan);
			phi_ok_s2 <= phi_ok;
		end
	end

	// Stage 2: tan product window test.
	logic signed [XW:0] dtan;
	logic [XW-1:0]      dtan_abs;
	logic               tan_ok;

	assign dtan     = $signed({1'b0, prod_s2})
		- $signed((XW + 1)'({tan_mean_q, {epef_pkg::FRAC_W{1'b0}}}));
	assign dtan_abs = dtan[XW] ? XW'(-dtan) : XW'(dtan);
	assign tan_ok   = dtan_abs < XW'({tan_width_q, {epef_pkg::FRAC_W{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			pair_q  <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_issue;
			vld_s2 <= vld_s1;
			if (cmd.scan_start) idx_q <= '0;
			else if (cmd.scan_issue) idx_q <= idx_q + 1'b1;
			if (cmd.emit) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				pair_q  <= 1'b0;
			end else begin
				if (cmd.store) count_q <= count_q + 1'b1;
				if (cmd.set_ovf) ovf_q <= 1'b1;
				if (vld_s2 && phi_ok_s2 && tan_ok) pair_q <= 1'b1;
			end
		end
	end

	// Result register; it holds a verdict while the next item is taken in.
	epef_pkg::verdict_t         verdict_d;
	logic [epef_pkg::VERD_W-1:0] verdict_q;
	logic [epef_pkg::COUNT_W-1:0] count_out_q;
	logic                         out_valid_q;

	always_comb begin
		if (!trig_q[epef_pkg::TRIG_BIT]) verdict_d = epef_pkg::VERDICT_NO_TRIGGER;
		else if (ovf_q) verdict_d = epef_pkg::VERDICT_OVERFLOW;
		else if (count_q < epef_pkg::CNT_W'(2)) verdict_d = epef_pkg::VERDICT_FEW_TRACKS;
		else if (!pair_q) verdict_d = epef_pkg::VERDICT_NO_PAIR;
		else verdict_d = epef_pkg::VERDICT_ACCEPT;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			verdict_q   <= verdict_d;
			count_out_q <= epef_pkg::COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign track_count = count_out_q;

	assign status.qual      = qual_q;
	assign status.eoe       = eoe_q;
	assign status.ovf       = ovf_q;
	assign status.at_limit  = epef_pkg::CMP_W'(count_q) >= limit;
	assign status.scan_done = idx_q == count_q;
	assign status.busy      = vld_s1 || vld_s2;
	assign status.out_full  = out_valid_q && !out_ready;

	// A track is written only after every comparison for it has settled.
	a_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !vld_s1 && !vld_s2)
		else $error("track stored while comparisons are in flight");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> idx_q < count_q)
		else $error("scan reads beyond the stored tracks");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> epef_pkg::CMP_W'(count_q) < limit)
		else $error("track stored beyond the track limit");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> count_q == '0 && !ovf_q && !pair_q && out_valid_q)
		else $error("event state not cleared after the verdict");

endmodule

`default_nettype wire

FILE: rtl/core/elastic_pair_event_filter.sv
// Two-body elastic event filter.
// Input channel (in_valid/in_ready) takes one track item per handshake; the
// item flagged end_of_event closes the event. Output channel
// (out_valid/out_ready) gives one verdict item per event with the number of
// stored qualifying tracks. Configuration writes use cfg_we, cfg_index and
// cfg_data and take effect at once; write them only while the block is idle.
// A qualifying track is compared with each of the n tracks already stored
// (up to 255), one per cycle through the track memory's single read port.
// After the last item the controller passes through its result state and
// loads the verdict into the output register once that register is free.
// Reset (arst_n low) clears the event state and the output valid flag and
// sets the configuration to its default values; the track memory is not cleared.
// A stalled receiver holds the verdict in the output register; the block
// keeps accepting items of the next event until a second verdict would be
// due, and then waits for the first one to be taken.
`default_nettype none

module elastic_pair_event_filter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [epef_pkg::TRIG_W-1:0]      trigger_bits,
	input  wire logic [epef_pkg::SECT_W-1:0]      track_sector,
	input  wire logic [epef_pkg::LPHI_W-1:0]      local_phi,
	input  wire logic [epef_pkg::THETA_W-1:0]     polar_theta,
	input  wire logic                             track_qualifies,
	input  wire logic                             end_of_event,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [epef_pkg::VERD_W-1:0]           verdict,
	output logic [epef_pkg::COUNT_W-1:0]          track_count,
	input  wire logic                             cfg_we,
	input  wire logic [epef_pkg::CIDX_W-1:0]      cfg_index,
	input  wire logic [epef_pkg::CFG_W-1:0]       cfg_data
);

	epef_pkg::cmd_t    cmd;
	epef_pkg::status_t status;

	epef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	epef_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.trigger_bits    (trigger_bits),
		.track_sector    (track_sector),
		.local_phi       (local_phi),
		.polar_theta     (polar_theta),
		.track_qualifies (track_qualifies),
		.end_of_event    (end_of_event),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.track_count     (track_count)
	);

endmodule

`default_nettype wire
